@@ rtl/pdb_pkg.sv @@
package pdb_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_WIDTH     = 16;
    localparam int ROTATION_STAGES = 16;

    localparam int RANGE_WIDTH = 25;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int CFG_WIDTH   = (RANGE_WIDTH > COORD_WIDTH) ? RANGE_WIDTH : COORD_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam int SQ_WIDTH    = 2 * DIFF_WIDTH;
    localparam int LIM_WIDTH   = 2 * RANGE_WIDTH;
    localparam int CMP_WIDTH   = (SQ_WIDTH > LIM_WIDTH) ? SQ_WIDTH : LIM_WIDTH;
    localparam int SQRT_STEPS  = DIFF_WIDTH;
    localparam int REM_WIDTH   = DIFF_WIDTH + 3;

    localparam int SCALE_SHIFT = 24;
    localparam int CORDIC_WIDTH = DIFF_WIDTH + SCALE_SHIFT + 3;
    localparam int ROT_COUNT   = (ROTATION_STAGES < 32) ? ROTATION_STAGES : 32;
    localparam int ANGLE_SHIFT = 32 - ANGLE_WIDTH;

    localparam int PIPE_DEPTH  = ((1 + SQRT_STEPS) > ROT_COUNT) ? (1 + SQRT_STEPS) : ROT_COUNT;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_X_LOW   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_X_HIGH  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_Y_LOW   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_Y_HIGH  = 3'd4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
    } point_t;

    typedef struct packed {
        logic [DIFF_WIDTH-1:0]         distance;
        logic signed [ANGLE_WIDTH-1:0] bearing;
        logic                          in_range;
        logic                          in_box;
    } result_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_low;
        logic signed [COORD_WIDTH-1:0] x_high;
        logic signed [COORD_WIDTH-1:0] y_low;
        logic signed [COORD_WIDTH-1:0] y_high;
    } box_t;

    typedef struct packed {
        logic signed [DIFF_WIDTH-1:0] dx;
        logic signed [DIFF_WIDTH-1:0] dy;
        logic                         in_box;
    } job_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/pdb_front.sv @@
module pdb_front import pdb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pt_valid,
    output logic    pt_ready,
    input  point_t  pt,
    input  box_t    box,
    output logic    job_valid,
    input  logic    job_ready,
    output job_t    job
);

    logic valid_reg;
    job_t job_reg;
    job_t job_next;

    assign pt_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        job_next.dx = DIFF_WIDTH'(pt.second_x) - DIFF_WIDTH'(pt.first_x);
        job_next.dy = DIFF_WIDTH'(pt.second_y) - DIFF_WIDTH'(pt.first_y);
        job_next.in_box = (pt.second_x > box.x_low) && (pt.second_x < box.x_high) &&
                          (pt.second_y > box.y_low) && (pt.second_y < box.y_high);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pt_ready)
        begin
            valid_reg <= pt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_valid && pt_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

@@ rtl/pdb_queue.sv @@
module pdb_queue import pdb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_item,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_item
);

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count missed a pop");

endmodule

@@ rtl/pdb_back.sv @@
module pdb_back import pdb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  job_t                   job,
    input  logic [RANGE_WIDTH-1:0] range_limit,
    output logic                   res_valid,
    input  logic                   res_ready,
    output result_t                res
);

    typedef struct packed {
        logic [SQ_WIDTH-1:0]            sq_a;
        logic [SQ_WIDTH-1:0]            sq_b;
        logic [LIM_WIDTH-1:0]           lim2;
        logic [SQ_WIDTH-1:0]            rad;
        logic [REM_WIDTH-1:0]           rem;
        logic [DIFF_WIDTH-1:0]          root;
        logic                           in_range;
        logic signed [CORDIC_WIDTH-1:0] cx;
        logic signed [CORDIC_WIDTH-1:0] cy;
        logic [31:0]                    cz;
        logic                           zero;
        logic                           in_box;
    } stage_t;

    stage_t  st_reg  [PIPE_DEPTH+1];
    logic    vld_reg [PIPE_DEPTH+1];
    stage_t  st_next [PIPE_DEPTH+1];
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    advance;

    logic [DIFF_WIDTH-1:0]          ax;
    logic [DIFF_WIDTH-1:0]          ay;
    logic signed [CORDIC_WIDTH-1:0] sx;
    logic signed [CORDIC_WIDTH-1:0] sy;
    logic [31:0]                    zr;

    assign advance   = !res_valid_reg || res_ready;
    assign job_ready = advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // magnitudes, squares and half-turn pre-rotation
    always_comb
    begin
        ax = job.dx[DIFF_WIDTH-1] ? (~job.dx + 1'b1) : job.dx;
        ay = job.dy[DIFF_WIDTH-1] ? (~job.dy + 1'b1) : job.dy;
        sx = CORDIC_WIDTH'(job.dx) <<< SCALE_SHIFT;
        sy = CORDIC_WIDTH'(job.dy) <<< SCALE_SHIFT;
        zr = 32'd0;
        if (job.dx[DIFF_WIDTH-1])
        begin
            sx = -sx;
            sy = -sy;
            zr = 32'h8000_0000;
        end
        st_next[0]          = '0;
        st_next[0].sq_a     = ax * ax;
        st_next[0].sq_b     = ay * ay;
        st_next[0].lim2     = range_limit * range_limit;
        st_next[0].cx       = sx;
        st_next[0].cy       = sy;
        st_next[0].cz       = zr;
        st_next[0].zero     = (job.dx == '0) && (job.dy == '0);
        st_next[0].in_box   = job.in_box;
    end

    for (genvar k = 1; k <= PIPE_DEPTH; k++)
    begin : g_stage
        logic [SQ_WIDTH-1:0]            sum;
        logic [REM_WIDTH-1:0]           rem_s;
        logic [REM_WIDTH-1:0]           trial;
        logic signed [CORDIC_WIDTH-1:0] xs;
        logic signed [CORDIC_WIDTH-1:0] ys;

        always_comb
        begin
            st_next[k] = st_reg[k-1];
            sum   = st_reg[k-1].sq_a + st_reg[k-1].sq_b;
            rem_s = {st_reg[k-1].rem[REM_WIDTH-3:0], st_reg[k-1].rad[SQ_WIDTH-1 -: 2]};
            trial = REM_WIDTH'({st_reg[k-1].root, 2'b01});
            xs    = st_reg[k-1].cx >>> (k - 1);
            ys    = st_reg[k-1].cy >>> (k - 1);
            if (k == 1)
            begin
                st_next[k].rad      = sum;
                st_next[k].rem      = '0;
                st_next[k].root     = '0;
                st_next[k].in_range = CMP_WIDTH'(sum) < CMP_WIDTH'(st_reg[k-1].lim2);
            end
            if ((k >= 2) && (k - 2 < SQRT_STEPS))
            begin
                st_next[k].rad = st_reg[k-1].rad << 2;
                if (rem_s >= trial)
                begin
                    st_next[k].rem  = rem_s - trial;
                    st_next[k].root = {st_reg[k-1].root[DIFF_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    st_next[k].rem  = rem_s;
                    st_next[k].root = {st_reg[k-1].root[DIFF_WIDTH-2:0], 1'b0};
                end
            end
            if (k - 1 < ROT_COUNT)
            begin
                if (!st_reg[k-1].cy[CORDIC_WIDTH-1])
                begin
                    st_next[k].cx = st_reg[k-1].cx + ys;
                    st_next[k].cy = st_reg[k-1].cy - xs;
                    st_next[k].cz = st_reg[k-1].cz + atan_turn(k - 1);
                end
                else
                begin
                    st_next[k].cx = st_reg[k-1].cx - ys;
                    st_next[k].cy = st_reg[k-1].cy + xs;
                    st_next[k].cz = st_reg[k-1].cz - atan_turn(k - 1);
                end
            end
        end
    end

    for (genvar k = 0; k <= PIPE_DEPTH; k++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= (k == 0) ? job_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // rounding of root and angle
    always_comb
    begin
        logic [31:0] zround;
        zround = st_reg[PIPE_DEPTH].cz + (32'd1 << (ANGLE_SHIFT - 1));
        res_next.distance = (st_reg[PIPE_DEPTH].rem > REM_WIDTH'(st_reg[PIPE_DEPTH].root)) ?
                            st_reg[PIPE_DEPTH].root + 1'b1 : st_reg[PIPE_DEPTH].root;
        res_next.bearing  = st_reg[PIPE_DEPTH].zero ? '0 : zround[31 -: ANGLE_WIDTH];
        res_next.in_range = st_reg[PIPE_DEPTH].in_range;
        res_next.in_box   = st_reg[PIPE_DEPTH].in_box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= vld_reg[PIPE_DEPTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.distance == '0)) |-> (res.bearing == '0))
        else $error("coincident points with nonzero bearing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.in_range) |-> (res.distance <= DIFF_WIDTH'(range_limit)))
        else $error("in range beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

@@ rtl/point_distance_bearing.sv @@
// channel  | valid / ready          | payload
// pt       | pt_valid / pt_ready    | first_x, first_y, second_x, second_y
// res      | res_valid / res_ready  | distance, bearing, in_range, in_box
// cfg      | cfg_we (no ready)      | cfg_index, cfg_data
//
// one item per cycle sustained while res is not stalled; the back pipeline depth PIPE_DEPTH is
// set by the square root pipeline, one root bit per stage
// rst_n clears all valid flags and loads the register reset values
// a stall on res freezes the back pipeline; the front keeps taking items until the queue fills
module point_distance_bearing import pdb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pt_valid,
    output logic                       pt_ready,
    input  point_t                     pt,
    output logic                       res_valid,
    input  logic                       res_ready,
    output result_t                    res,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

    logic [RANGE_WIDTH-1:0] range_limit_reg;
    box_t                   box_reg;
    logic                   fq_valid;
    logic                   fq_ready;
    job_t                   fq_item;
    logic                   qb_valid;
    logic                   qb_ready;
    job_t                   qb_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= '0;
            box_reg.x_low   <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
            box_reg.x_high  <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
            box_reg.y_low   <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
            box_reg.y_high  <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LIMIT: range_limit_reg <= cfg_data[RANGE_WIDTH-1:0];
                REG_BOX_X_LOW:   box_reg.x_low   <= cfg_data[COORD_WIDTH-1:0];
                REG_BOX_X_HIGH:  box_reg.x_high  <= cfg_data[COORD_WIDTH-1:0];
                REG_BOX_Y_LOW:   box_reg.y_low   <= cfg_data[COORD_WIDTH-1:0];
                REG_BOX_Y_HIGH:  box_reg.y_high  <= cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    pdb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt        (pt),
        .box       (box_reg),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_item)
    );

    pdb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    pdb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (qb_valid),
        .job_ready   (qb_ready),
        .job         (qb_item),
        .range_limit (range_limit_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule
